// ===== rtl/lcar_pkg.sv =====
// Shared types and constants for the load cell ADC reader.
// Field widths, register reset values, register indexes and state codes.
// No dependencies.
package lcar_pkg;

   localparam int RAW_W       = 24;
   localparam int NET_W       = 25;
   localparam int WEIGHT_W    = 25;
   localparam int SCALE_W     = 25;
   localparam int COUNT_W     = 5;
   localparam int Q_SHIFT     = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 25;

   localparam logic [COUNT_W-1:0]       SAMPLE_COUNT_RST = 5'd10;
   localparam logic signed [RAW_W-1:0]  ZERO_OFFSET_RST  = 24'sd127500;
   localparam logic [SCALE_W-1:0]       SCALE_RST        = 25'd155858;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLE_COUNT = 2'd0,
      CSR_ZERO_OFFSET  = 2'd1,
      CSR_SCALE        = 2'd2
   } lcar_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_NET,
      ST_MUL,
      ST_OUT
   } lcar_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lcar_unit_stat_type;

endpackage

// ===== rtl/lcar_if.sv =====
// Handshake channels of the load cell ADC reader: tick words in, result words out.
// Depends on lcar_pkg for the result field widths.
interface lcar_req_if;
   logic valid;
   logic ready;
   logic data_level;

   modport source (output valid, output data_level, input ready);
   modport sink (input valid, input data_level, output ready);
endinterface

interface lcar_rsp_if import lcar_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       clock_level;
   logic                       reading_valid;
   logic signed [RAW_W-1:0]    raw_average;
   logic signed [NET_W-1:0]    net_reading;
   logic signed [WEIGHT_W-1:0] weight_decigrams;

   modport source (output valid, output clock_level, output reading_valid,
                   output raw_average, output net_reading, output weight_decigrams,
                   input ready);
   modport sink (input valid, input clock_level, input reading_valid,
                 input raw_average, input net_reading, input weight_decigrams,
                 output ready);
endinterface

// ===== rtl/lcar_div.sv =====
// Bit-serial restoring divider: signed sum over a small unsigned count,
// one quotient bit per cycle, truncating toward zero. Depends on lcar_pkg.
module lcar_div import lcar_pkg::*; #(
   parameter int SUM_W = 28,
   parameter int CNT_W = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0]        divisor,
   output logic signed [SUM_W-1:0] quotient,
   output lcar_unit_stat_type      stat
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]        work_ff, work_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        dsr_ff, dsr_in;
   logic                    neg_ff, neg_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic signed [SUM_W-1:0] quot_ff, quot_in;
   logic [CNT_W:0]          trial;
   logic                    fits;

   always_comb begin
      trial    = {rem_ff, work_ff[SUM_W-1]};
      fits     = trial >= {1'b0, dsr_ff};
      work_in  = work_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      quot_in  = quot_ff;
      if (start) begin
         work_in = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in  = '0;
         dsr_in  = divisor;
         neg_in  = dividend[SUM_W-1];
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[SUM_W-2:0], fits};
         rem_in  = fits ? CNT_W'(trial - {1'b0, dsr_ff}) : CNT_W'(trial);
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = neg_ff ? -signed'(work_in) : signed'(work_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign quotient  = quot_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/lcar_mul.sv =====
// Bit-serial shift-add multiplier: signed net value times unsigned Q24 scale,
// one scale bit per cycle, full-width product. Depends on lcar_pkg.
module lcar_mul import lcar_pkg::*; (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [NET_W-1:0]             multiplicand,
   input  logic [SCALE_W-1:0]                  multiplier,
   output logic signed [NET_W+SCALE_W:0]       product,
   output lcar_unit_stat_type                  stat
);

   localparam int STEP_W = $clog2(SCALE_W + 1);

   logic signed [NET_W:0]   hi_ff, hi_in;
   logic [SCALE_W-1:0]      lo_ff, lo_in;
   logic signed [NET_W-1:0] mcand_ff, mcand_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic signed [NET_W:0]   partial;

   always_comb begin
      partial  = lo_ff[0] ? hi_ff + (NET_W+1)'(mcand_ff) : hi_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         hi_in    = '0;
         lo_in    = multiplier;
         mcand_in = multiplicand;
         step_in  = STEP_W'(SCALE_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in   = {partial[NET_W], partial[NET_W:1]};
         lo_in   = {partial[0], lo_ff[SCALE_W-1:1]};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
   end

   assign product   = {hi_ff, lo_ff};
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/load_cell_adc_reader_core.sv =====
// Load cell ADC reader: serial clocking of the converter, averaging and scaling.
// A tick word that does not finish an average is answered from the output register in the cycle after it is taken.
// A finishing tick is answered once the bit-serial divider and then the bit-serial 25-bit
// scale multiplier have run.
// No new tick is taken until that tick's word is in the output register.
// Synchronous reset returns the block to idle and the registers to their defaults.
module load_cell_adc_reader_core import lcar_pkg::*; #(
   parameter int DATA_BITS   = 24,
   parameter int MAX_AVERAGE = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   lcar_req_if.sink               req_ch,
   lcar_rsp_if.source             rsp_ch
);

   localparam int SUM_W     = DATA_BITS + $clog2(MAX_AVERAGE);
   localparam int CNT_W     = $clog2(MAX_AVERAGE + 1);
   localparam int CMP_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int PH_W      = $clog2(2 * DATA_BITS + 2);
   localparam int EXT_W     = (SUM_W > NET_W) ? SUM_W : NET_W;
   localparam int PROD_W    = NET_W + SCALE_W + 1;
   localparam int WT_FULL_W = PROD_W - Q_SHIFT;

   localparam logic [PH_W-1:0]             PH_LAST = PH_W'(2 * DATA_BITS);
   localparam logic [PH_W-1:0]             PH_GAIN = PH_W'(2 * DATA_BITS + 1);
   localparam logic [CMP_W-1:0]            N_MAX   = CMP_W'(MAX_AVERAGE);
   localparam logic signed [EXT_W-1:0]     AVG_HI  = EXT_W'((1 << (RAW_W - 1)) - 1);
   localparam logic signed [EXT_W-1:0]     AVG_LO  = -AVG_HI - 1;
   localparam logic signed [WT_FULL_W-1:0] WT_HI   = WT_FULL_W'((1 << (WEIGHT_W - 1)) - 1);
   localparam logic signed [WT_FULL_W-1:0] WT_LO   = -WT_HI - 1;

   logic [COUNT_W-1:0]        sample_count_ff;
   logic signed [RAW_W-1:0]   zero_offset_ff;
   logic [SCALE_W-1:0]        scale_ff;

   lcar_state_type            state_ff, state_in;
   logic [PH_W-1:0]           phase_ff, phase_in;
   logic [DATA_BITS-1:0]      shift_ff, shift_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]          readings_ff, readings_in;
   logic signed [RAW_W-1:0]   avg_ff, avg_in;
   logic signed [NET_W-1:0]   net_ff, net_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      clock_level_ff;
   logic                      reading_valid_ff;
   logic signed [RAW_W-1:0]   raw_avg_ff;
   logic signed [NET_W-1:0]   net_out_ff;
   logic signed [WEIGHT_W-1:0] weight_ff;

   logic                      write_out;
   logic                      out_clk;
   logic                      out_reading;
   logic signed [RAW_W-1:0]   out_avg;
   logic signed [NET_W-1:0]   out_net;
   logic signed [WEIGHT_W-1:0] out_weight;

   logic                      accept;
   logic                      out_free;
   logic signed [SUM_W-1:0]   sum_next;
   logic [CMP_W-1:0]          sc_ext;
   logic [CMP_W-1:0]          n_eff;
   logic [CMP_W-1:0]          count_next;
   logic                      complete;
   logic signed [EXT_W-1:0]   avg_ext;
   logic signed [WT_FULL_W-1:0] wt_full;

   logic                      div_start;
   logic signed [SUM_W-1:0]   div_quot;
   lcar_unit_stat_type        div_stat;
   logic                      mul_start;
   logic signed [PROD_W-1:0]  mul_prod;
   lcar_unit_stat_type        mul_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_COUNT_RST;
         zero_offset_ff  <= ZERO_OFFSET_RST;
         scale_ff        <= SCALE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_ZERO_OFFSET:  zero_offset_ff  <= signed'(csr_wdata[RAW_W-1:0]);
            CSR_SCALE:        scale_ff        <= csr_wdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign out_free       = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready   = (state_ff == ST_IDLE) && out_free;
   assign accept         = req_ch.valid && req_ch.ready;

   assign sum_next   = sum_ff + SUM_W'(signed'(shift_ff));
   assign sc_ext     = CMP_W'(sample_count_ff);
   assign n_eff      = (sc_ext == '0) ? CMP_W'(1) : ((sc_ext > N_MAX) ? N_MAX : sc_ext);
   assign count_next = CMP_W'(readings_ff) + CMP_W'(1);
   assign complete   = count_next >= n_eff;
   assign avg_ext    = EXT_W'(div_quot);
   assign wt_full    = mul_prod[PROD_W-1:Q_SHIFT];

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      shift_in     = shift_ff;
      sum_in       = sum_ff;
      readings_in  = readings_ff;
      avg_in       = avg_ff;
      net_in       = NET_W'(avg_ff) - NET_W'(zero_offset_ff);
      div_start    = 1'b0;
      mul_start    = 1'b0;
      write_out    = 1'b0;
      out_clk      = 1'b0;
      out_reading  = 1'b0;
      out_avg      = '0;
      out_net      = '0;
      out_weight   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (phase_ff == '0) begin
                  write_out = 1'b1;
                  if (!req_ch.data_level) begin
                     out_clk  = 1'b1;
                     phase_in = PH_W'(1);
                  end
               end else if (phase_ff <= PH_LAST) begin
                  write_out = 1'b1;
                  phase_in  = phase_ff + 1'b1;
                  if (!phase_ff[0]) begin
                     shift_in = {shift_ff[DATA_BITS-2:0], req_ch.data_level};
                     out_clk  = 1'b1;
                  end
               end else begin
                  phase_in = '0;
                  shift_in = '0;
                  if (complete) begin
                     sum_in      = '0;
                     readings_in = '0;
                     div_start   = 1'b1;
                     state_in    = ST_DIV;
                  end else begin
                     sum_in      = sum_next;
                     readings_in = CNT_W'(count_next);
                     write_out   = 1'b1;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (avg_ext > AVG_HI) begin
                  avg_in = AVG_HI[RAW_W-1:0];
               end else if (avg_ext < AVG_LO) begin
                  avg_in = AVG_LO[RAW_W-1:0];
               end else begin
                  avg_in = avg_ext[RAW_W-1:0];
               end
               state_in = ST_NET;
            end
         end
         ST_NET: begin
            mul_start = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (mul_stat.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               write_out   = 1'b1;
               out_reading = 1'b1;
               out_avg     = avg_ff;
               out_net     = net_ff;
               if (wt_full > WT_HI) begin
                  out_weight = WT_HI[WEIGHT_W-1:0];
               end else if (wt_full < WT_LO) begin
                  out_weight = WT_LO[WEIGHT_W-1:0];
               end else begin
                  out_weight = wt_full[WEIGHT_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = write_out || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         shift_ff     <= '0;
         sum_ff       <= '0;
         readings_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         sum_ff       <= sum_in;
         readings_ff  <= readings_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      avg_ff <= avg_in;
      if (state_ff == ST_NET) begin
         net_ff <= net_in;
      end
      if (write_out) begin
         clock_level_ff   <= out_clk;
         reading_valid_ff <= out_reading;
         raw_avg_ff       <= out_avg;
         net_out_ff       <= out_net;
         weight_ff        <= out_weight;
      end
   end

   lcar_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_next),
      .divisor  (CNT_W'(count_next)),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   lcar_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (net_in),
      .multiplier   (scale_ff),
      .product      (mul_prod),
      .stat         (mul_stat)
   );

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.clock_level      = clock_level_ff;
   assign rsp_ch.reading_valid    = reading_valid_ff;
   assign rsp_ch.raw_average      = raw_avg_ff;
   assign rsp_ch.net_reading      = net_out_ff;
   assign rsp_ch.weight_decigrams = weight_ff;

`ifndef SYNTHESIS
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV)
      else $error("Divider finished outside the divide state.");

   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> state_ff == ST_MUL)
      else $error("Multiplier finished outside the multiply state.");

   a_units_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_stat.busy && !mul_stat.busy)
      else $error("Arithmetic unit busy while the sequencer is idle.");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_GAIN && int'(readings_ff) < MAX_AVERAGE)
      else $error("Bit phase or reading count out of range.");

   a_idle_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !reading_valid_ff |->
         raw_avg_ff == '0 && net_out_ff == '0 && weight_ff == '0)
      else $error("Result fields nonzero on a word without a reading.");
`endif

endmodule

// ===== tb/load_cell_adc_reader_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for load_cell_adc_reader_core: converter pin ticks in, result words out.
// A scoreboard class predicts each result word and compares it field by field.
// Depends on lcar_pkg, lcar_req_if and lcar_rsp_if.
module load_cell_adc_reader_core_tb;
   import lcar_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1500000;
   localparam int unsigned LAST_BIT_PHASE = 48;
   localparam int unsigned TICK_BUDGET = 1600;

   typedef struct {
      logic                       clock_level;
      logic                       reading_valid;
      logic signed [RAW_W-1:0]    raw_average;
      logic signed [NET_W-1:0]    net_reading;
      logic signed [WEIGHT_W-1:0] weight_decigrams;
   } tick_word_type;

   class reading_scoreboard;
      logic [COUNT_W-1:0] avg_count;
      longint             tare;
      longint             scale_q24;
      int unsigned        bit_phase;
      logic [RAW_W-1:0]   shift_bits;
      longint             reading_sum;
      int unsigned        readings_held;
      tick_word_type      pending[$];
      int unsigned        errors;

      function new();
         avg_count     = SAMPLE_COUNT_RST;
         tare          = longint'(ZERO_OFFSET_RST);
         scale_q24     = longint'(SCALE_RST);
         bit_phase     = 0;
         shift_bits    = '0;
         reading_sum   = 0;
         readings_held = 0;
         errors        = 0;
      endfunction

      function void write_reg(lcar_csr_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_SAMPLE_COUNT: avg_count = value[COUNT_W-1:0];
            CSR_ZERO_OFFSET: tare = longint'($signed(value[RAW_W-1:0]));
            CSR_SCALE: scale_q24 = longint'(value[SCALE_W-1:0]);
            default: ;
         endcase
      endfunction

      function void take_tick(bit level);
         tick_word_type w;
         int unsigned   needed;
         longint        avg;
         longint        net;
         longint        wt;
         w.clock_level      = 1'b0;
         w.reading_valid    = 1'b0;
         w.raw_average      = '0;
         w.net_reading      = '0;
         w.weight_decigrams = '0;
         if (bit_phase == 0) begin
            if (!level) begin
               w.clock_level = 1'b1;
               bit_phase = 1;
            end
         end else if (bit_phase <= LAST_BIT_PHASE && bit_phase % 2 == 1) begin
            bit_phase++;
         end else if (bit_phase <= LAST_BIT_PHASE) begin
            shift_bits = {shift_bits[RAW_W-2:0], level};
            w.clock_level = 1'b1;
            bit_phase++;
         end else begin
            bit_phase = 0;
            reading_sum += longint'($signed(shift_bits));
            shift_bits = '0;
            readings_held++;
            needed = (avg_count == 0) ? 1 : (avg_count > 16) ? 16 : avg_count;
            if (readings_held >= needed) begin
               avg = reading_sum / longint'(readings_held);
               if (avg < -8388608) avg = -8388608;
               if (avg > 8388607) avg = 8388607;
               net = avg - tare;
               wt = (net * scale_q24) >>> Q_SHIFT;
               if (wt < -16777216) wt = -16777216;
               if (wt > 16777215) wt = 16777215;
               w.reading_valid    = 1'b1;
               w.raw_average      = avg[RAW_W-1:0];
               w.net_reading      = net[NET_W-1:0];
               w.weight_decigrams = wt[WEIGHT_W-1:0];
               reading_sum   = 0;
               readings_held = 0;
            end
         end
         pending.push_back(w);
      endfunction

      function void flag(string field, logic signed [31:0] want, logic signed [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void compare_word(tick_word_type got);
         tick_word_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, expected none, actual clock %0b valid %0b",
                     $time, got.clock_level, got.reading_valid);
            return;
         end
         want = pending.pop_front();
         flag("clock_level", want.clock_level, got.clock_level);
         flag("reading_valid", want.reading_valid, got.reading_valid);
         flag("raw_average", want.raw_average, got.raw_average);
         flag("net_reading", want.net_reading, got.net_reading);
         flag("weight_decigrams", want.weight_decigrams, got.weight_decigrams);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   lcar_req_if req_ch ();
   lcar_rsp_if rsp_ch ();

   load_cell_adc_reader_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   reading_scoreboard sb;
   bit                idling = 1'b1;
   int unsigned       ticks_sent = 0;
   int unsigned       stall_left = 0;
   int unsigned       cycles = 0;
   tick_word_type     seen;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("load_cell_adc_reader_core_tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen.clock_level      = rsp_ch.clock_level;
         seen.reading_valid    = rsp_ch.reading_valid;
         seen.raw_average      = rsp_ch.raw_average;
         seen.net_reading      = rsp_ch.net_reading;
         seen.weight_decigrams = rsp_ch.weight_decigrams;
         sb.compare_word(seen);
      end
      if (idling && stall_left == 0 && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 9);
      if (idling && stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_tick(bit level);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.data_level <= level;
      do @(posedge clock); while (!req_ch.ready);
      sb.take_tick(level);
      ticks_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(int unsigned count, longint offset, longint scale);
      logic [CSR_DATA_W-1:0] value;
      value = CSR_DATA_W'(count);
      csr_we    <= 1'b1;
      csr_index <= CSR_SAMPLE_COUNT;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(CSR_SAMPLE_COUNT, value);
      value = CSR_DATA_W'(offset);
      csr_index <= CSR_ZERO_OFFSET;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(CSR_ZERO_OFFSET, value);
      value = CSR_DATA_W'(scale);
      csr_index <= CSR_SCALE;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(CSR_SCALE, value);
      csr_we <= 1'b0;
   endtask

   // Sends one conversion: idle ticks with the data pin high, the start tick, then the
   // 24 data bits and the gain pulse. Noise sets the pin level at random on random ticks.
   task automatic run_reading(logic [RAW_W-1:0] value, int unsigned lead, bit noisy);
      bit level;
      bit started;
      int unsigned ph;
      started = 1'b0;
      repeat (lead) begin
         if (sb.bit_phase == 0) send_tick(1'b1);
      end
      do begin
         ph = sb.bit_phase;
         if (ph == 0) begin
            level = 1'b0;
            started = 1'b1;
         end else if (ph % 2 == 0 && ph <= LAST_BIT_PHASE) begin
            level = value[RAW_W - ph / 2];
         end else begin
            level = $urandom_range(0, 1);
         end
         if (noisy && $urandom_range(0, 19) == 0) level = $urandom_range(0, 1);
         send_tick(level);
      end while (!(started && sb.bit_phase == 0));
   endtask

   function automatic logic [RAW_W-1:0] pick_reading();
      case ($urandom_range(0, 7))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'h000000;
         3: return 24'hFFFFFF;
         default: return RAW_W'($urandom);
      endcase
   endfunction

   function automatic longint pick_offset();
      case ($urandom_range(0, 7))
         0: return -8388608;
         1: return 8388607;
         2: return 0;
         default: return longint'($signed(RAW_W'($urandom)));
      endcase
   endfunction

   function automatic longint pick_scale();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 1;
         2: return 33554431;
         3: return 16777216;
         default: return longint'($urandom_range(0, 33554431));
      endcase
   endfunction

   initial begin
      int unsigned count;
      int unsigned needed;
      int unsigned n_readings;
      sb = new();
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_SAMPLE_COUNT;
      csr_wdata         <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.data_level <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The first reading is taken at the reset defaults; lowering the count then ends
      // the average early over the two readings held.
      run_reading(24'h123456, 3, 1'b0);
      wait_drained();
      set_config(1, -8388608, 0);
      run_reading(24'h7FFFFF, 1, 1'b0);
      wait_drained();
      set_config(0, 8388607, 33554431);
      run_reading(24'h800000, 0, 1'b0);
      wait_drained();
      set_config(2, 0, 16777216);
      run_reading(24'hFFFFFF, 0, 1'b0);
      run_reading(24'h000001, 2, 1'b0);
      run_reading(24'hFFFFFF, 0, 1'b0);
      run_reading(24'hFFFFFE, 0, 1'b0);
      wait_drained();
      set_config(31, 8388607, 1);
      run_reading(24'h000000, 0, 1'b0);
      wait_drained();
      set_config(17, -1, 33554431);
      run_reading(24'h7FFFFF, 1, 1'b0);

      while (ticks_sent < TICK_BUDGET) begin
         case ($urandom_range(0, 15))
            0: count = 0;
            1: count = ($urandom_range(0, 1) == 0) ? 16 : 31;
            2: count = $urandom_range(5, 15);
            default: count = $urandom_range(1, 4);
         endcase
         needed = (count == 0) ? 1 : (count > 16) ? 16 : count;
         n_readings = needed * $urandom_range(1, 3) + $urandom_range(0, 1);
         wait_drained();
         set_config(count, pick_offset(), pick_scale());
         repeat (n_readings) begin
            if (ticks_sent < TICK_BUDGET)
               run_reading(pick_reading(), $urandom_range(0, 3), 1'b1);
         end
      end

      wait_drained();
      idling = 1'b0;
      set_config(1, pick_offset(), pick_scale());
      repeat (6) run_reading(pick_reading(), $urandom_range(0, 2), 1'b0);

      wait_drained();
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("load_cell_adc_reader_core_tb: clean");
      end else begin
         $display("load_cell_adc_reader_core_tb: errors");
      end
      $finish;
   end

endmodule
